### sv/sfba_pkg.sv
// Shared types and constants for the spreading-factor bin allocator.
// Holds the threshold tables, bin limits, action codes and result status codes.
// No dependencies.
package sfba_pkg;

  localparam int NUM_BINS = 6;
  localparam int IDX_W = 3;
  localparam int TOTAL_W = 12;
  localparam int SF_W = 4;

  localparam logic [SF_W-1:0] FIRST_SF = 4'd7;
  localparam logic [SF_W-1:0] LAST_SF = 4'd12;
  localparam logic [SF_W-1:0] NO_SF = 4'd0;

  localparam logic ACT_PLACE = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef logic [15:0] edge_t;
  typedef logic [TOTAL_W-1:0] total_t;

  localparam edge_t PERIOD_EDGE [NUM_BINS] = '{16'd3200, 16'd1600, 16'd800,
                                              16'd400, 16'd200, 16'd100};
  localparam edge_t DIST_EDGE [NUM_BINS] = '{16'd125, 16'd250, 16'd500,
                                            16'd1000, 16'd2000, 16'd4000};
  localparam total_t BIN_LIMIT [NUM_BINS] = '{12'd3598, 12'd1798, 12'd898,
                                             12'd448, 12'd223, 12'd110};

  typedef enum logic [1:0] {
    ST_PLACED     = 2'd0,
    ST_INFEASIBLE = 2'd1,
    ST_NO_FACTOR  = 2'd2,
    ST_CLEARED    = 2'd3
  } status_t;

  typedef struct packed {
    logic [SF_W-1:0] assigned;
    status_t         status;
  } alloc_res_t;

endpackage

### sv/spreading_factor_bin_allocator_unit.sv
// Top level of the spreading-factor bin allocator: input register, factor
// decode, bin state and result register. Depends on sfba_pkg, sfba_factor and sfba_bins.
//
// Channel | Direction | tdata (low bit up)                          | tuser
// in_     | slave     | node_id, distance_half_m, period_s, msg_cnt | action
// out_    | master    | node_id_out, min, max, assigned factor      | status
//
// One request is taken every cycle while out_tready holds; a result passes the input
// and result registers. Combinational bin pick and update between them set this rate.
// Reset clears all bin totals and full flags at once, with no clearing pass.
// A stalled result holds in the result register; the input register then fills and
// in_tready drops until the result is taken.
module spreading_factor_bin_allocator_unit import sfba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // node_id, distance_half_m, period_s, msg_count
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // node_id_out, min_factor, max_factor, assigned_factor
  output logic [1:0]  out_tuser   // status
);

  logic            in_valid_r;
  logic            action_r;
  logic [15:0]     node_id_r;
  logic [12:0]     dist_r;
  logic [15:0]     period_r;
  logic [7:0]      msg_r;

  logic            out_valid_r;
  logic [15:0]     out_id_r;
  logic [SF_W-1:0] out_min_r;
  logic [SF_W-1:0] out_max_r;
  logic [SF_W-1:0] out_asg_r;
  status_t         out_status_r;

  logic            advance;
  logic [SF_W-1:0] min_factor;
  logic [SF_W-1:0] max_factor;
  alloc_res_t      res;

  assign advance = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      action_r <= in_tuser;
      node_id_r <= in_tdata[15:0];
      dist_r <= in_tdata[28:16];
      period_r <= in_tdata[44:29];
      msg_r <= in_tdata[52:45];
    end
  end

  sfba_factor u_factor (
    .distance_half_m(dist_r),
    .period_s       (period_r),
    .min_factor     (min_factor),
    .max_factor     (max_factor)
  );

  sfba_bins u_bins (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .action    (action_r),
    .min_factor(min_factor),
    .msg_count (msg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= res.status;
      out_asg_r <= res.assigned;
      if (action_r == ACT_CLEAR) begin
        out_id_r <= '0;
        out_min_r <= NO_SF;
        out_max_r <= NO_SF;
      end else begin
        out_id_r <= node_id_r;
        out_min_r <= min_factor;
        out_max_r <= max_factor;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {4'b0000, out_asg_r, out_max_r, out_min_r, out_id_r};
  assign out_tuser = out_status_r;

endmodule

### sv/sfba_factor.sv
// Factor range decode: largest factor from the period, smallest from the distance.
// Pure combinational threshold compares.
// Depends on sfba_pkg.
module sfba_factor import sfba_pkg::*; (
  input  logic [12:0]     distance_half_m,
  input  logic [15:0]     period_s,
  output logic [SF_W-1:0] min_factor,
  output logic [SF_W-1:0] max_factor
);

  logic [SF_W-1:0] sf_dist;

  always_comb begin
    max_factor = NO_SF;
    sf_dist = NO_SF;
    for (int k = NUM_BINS - 1; k >= 0; k--) begin
      if (period_s > PERIOD_EDGE[k]) begin
        max_factor = LAST_SF - SF_W'(k);
      end
      if ({3'b000, distance_half_m} < DIST_EDGE[k]) begin
        sf_dist = FIRST_SF + SF_W'(k);
      end
    end
    min_factor = (sf_dist > max_factor) ? max_factor : sf_dist;
  end

endmodule

### sv/sfba_bins.sv
// Bin state for one gateway: message totals and full flags for factors 7 to 12.
// Picks the first free bin at or above the smallest factor and updates it.
// Depends on sfba_pkg.
module sfba_bins import sfba_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic            action,
  input  logic [SF_W-1:0] min_factor,
  input  logic [7:0]      msg_count,
  output alloc_res_t      res
);

  total_t              bin_total_r [NUM_BINS];
  total_t              bin_total_nxt [NUM_BINS];
  logic [NUM_BINS-1:0] bin_full_r;
  logic [NUM_BINS-1:0] bin_full_nxt;

  logic [NUM_BINS-1:0] eligible;
  logic [IDX_W-1:0]    pick_idx;
  logic                pick_found;
  total_t              pick_sum;

  always_comb begin
    pick_idx = '0;
    pick_found = 1'b0;
    for (int b = 0; b < NUM_BINS; b++) begin
      eligible[b] = (min_factor != NO_SF) && ((FIRST_SF + SF_W'(b)) >= min_factor) &&
                    !bin_full_r[b];
    end
    for (int b = NUM_BINS - 1; b >= 0; b--) begin
      if (eligible[b]) begin
        pick_idx = IDX_W'(b);
        pick_found = 1'b1;
      end
    end
    pick_sum = bin_total_r[pick_idx] + {4'b0000, msg_count};
  end

  always_comb begin
    res.assigned = NO_SF;
    if (action == ACT_CLEAR) begin
      res.status = ST_CLEARED;
    end else if (min_factor == NO_SF) begin
      res.status = ST_NO_FACTOR;
    end else if (pick_found) begin
      res.status = ST_PLACED;
      res.assigned = FIRST_SF + {1'b0, pick_idx};
    end else begin
      res.status = ST_INFEASIBLE;
    end
  end

  always_comb begin
    bin_total_nxt = bin_total_r;
    bin_full_nxt = bin_full_r;
    if (advance) begin
      if (action == ACT_CLEAR) begin
        for (int b = 0; b < NUM_BINS; b++) begin
          bin_total_nxt[b] = '0;
        end
        bin_full_nxt = '0;
      end else if (pick_found) begin
        for (int b = 0; b < NUM_BINS; b++) begin
          if (pick_idx == IDX_W'(b)) begin
            bin_total_nxt[b] = pick_sum;
            bin_full_nxt[b] = pick_sum > BIN_LIMIT[b];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        bin_total_r[b] <= '0;
      end
      bin_full_r <= '0;
    end else begin
      bin_total_r <= bin_total_nxt;
      bin_full_r <= bin_full_nxt;
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && action == ACT_CLEAR) |=> (bin_full_r == '0 && bin_total_r[0] == '0))
    else $error("Bins not emptied after a clear request.");

  a_placed_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res.status == ST_PLACED) |-> !bin_full_r[pick_idx])
    else $error("Request placed into a full bin.");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !advance) |=> $stable(bin_full_r))
    else $error("Full flags changed without a request.");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && advance && action == ACT_PLACE) |=>
      (($past(bin_full_r) & ~bin_full_r) == '0))
    else $error("A full flag dropped without a clear request.");

endmodule

### dv/sf_alloc_checker.sv
// Checker for the spreading-factor bin allocator: watches both stream channels,
// keeps its own bin totals and predicts every result. Depends on sfba_pkg.
// Hands its failure count and a tally of result kinds to the testbench top.
module sf_alloc_checker import sfba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,   // node_id, distance_half_m, period_s, msg_count
  input  logic        in_tuser,   // action
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // node_id_out, min_factor, max_factor, assigned_factor
  input  logic [1:0]  out_tuser,  // status
  output int          fail_count,
  output int          pending,
  output int          placed_count,
  output int          infeasible_count,
  output int          no_factor_count,
  output int          cleared_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD_STEP [6] = '{3200, 1600, 800, 400, 200, 100};
  localparam int DIST_STEP [6] = '{125, 250, 500, 1000, 2000, 4000};
  localparam int BIN_CAP [6] = '{3598, 1798, 898, 448, 223, 110};

  typedef struct packed {
    logic [15:0] node_id;
    logic [3:0]  min_sf;
    logic [3:0]  max_sf;
    logic [3:0]  bin_sf;
    status_t     status;
  } alloc_expect_t;

  logic [11:0]   bin_sum [6];
  logic          bin_over [6];
  alloc_expect_t alloc_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
    placed_count = 0;
    infeasible_count = 0;
    no_factor_count = 0;
    cleared_count = 0;
  end

  function automatic alloc_expect_t predict_allocation(logic act, logic [15:0] id,
                                                       logic [12:0] dist_hm,
                                                       logic [15:0] period,
                                                       logic [7:0] msgs);
    alloc_expect_t r;
    int top_sf;
    int low_sf;
    r = '0;
    if (act == ACT_CLEAR) begin
      for (int b = 0; b < 6; b++) begin
        bin_sum[b] = '0;
        bin_over[b] = 1'b0;
      end
      r.status = ST_CLEARED;
      return r;
    end
    top_sf = 0;
    for (int b = 0; b < 6; b++) begin
      if (top_sf == 0 && int'(period) > PERIOD_STEP[b]) top_sf = 12 - b;
    end
    low_sf = 0;
    for (int b = 0; b < 6; b++) begin
      if (low_sf == 0 && int'(dist_hm) < DIST_STEP[b]) low_sf = 7 + b;
    end
    if (low_sf > top_sf) low_sf = top_sf;
    r.node_id = id;
    r.min_sf = low_sf[3:0];
    r.max_sf = top_sf[3:0];
    if (low_sf == 0) begin
      r.status = ST_NO_FACTOR;
    end else begin
      r.status = ST_INFEASIBLE;
      // The first bin at or above the smallest factor that still has room takes the node.
      for (int b = low_sf - 7; b < 6; b++) begin
        if (r.status == ST_INFEASIBLE && !bin_over[b]) begin
          bin_sum[b] = bin_sum[b] + 12'(msgs);
          if (int'(bin_sum[b]) > BIN_CAP[b]) bin_over[b] = 1'b1;
          r.bin_sf = 4'(7 + b);
          r.status = ST_PLACED;
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    alloc_expect_t want;
    if (!rst_n) begin
      for (int b = 0; b < 6; b++) begin
        bin_sum[b] = '0;
        bin_over[b] = 1'b0;
      end
      alloc_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        want = predict_allocation(in_tuser, in_tdata[15:0], in_tdata[28:16],
                                  in_tdata[44:29], in_tdata[52:45]);
        alloc_q = {alloc_q, want};
        case (want.status)
          ST_PLACED:     placed_count++;
          ST_INFEASIBLE: infeasible_count++;
          ST_NO_FACTOR:  no_factor_count++;
          default:       cleared_count++;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (alloc_q.size() == 0) begin
          $error("result for node %0d arrived with no request outstanding",
                 out_tdata[15:0]);
          fail_count++;
        end else begin
          want = alloc_q.pop_front();
          check_field("node_id_out", want.node_id, out_tdata[15:0]);
          check_field("min_factor", want.min_sf, out_tdata[19:16]);
          check_field("max_factor", want.max_sf, out_tdata[23:20]);
          check_field("assigned_factor", want.bin_sf, out_tdata[27:24]);
          check_field("status", want.status, out_tuser);
        end
      end
    end
    pending = alloc_q.size();
  end

endmodule

### dv/testbench.sv
// Top of the allocator testbench: clock, reset, request stimulus and verdict.
// Runs a directed sequence and then sorted gateway fills with random stalls.
// Depends on sfba_pkg, spreading_factor_bin_allocator_unit and sf_alloc_checker.
module testbench import sfba_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int BAND_TOP [6] = '{124, 249, 499, 999, 1999, 3999};
  localparam int PERIOD_FLOOR [6] = '{101, 201, 401, 801, 1601, 3201};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // node_id, distance_half_m, period_s, msg_count
  logic        in_tuser;   // action
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // node_id_out, min_factor, max_factor, assigned_factor
  logic [1:0]  out_tuser;  // status

  int fail_count;
  int pending;
  int placed_count;
  int infeasible_count;
  int no_factor_count;
  int cleared_count;
  int send_idle_pct;
  int recv_idle_pct;
  int request_count;
  logic hold_armed;

  spreading_factor_bin_allocator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  sf_alloc_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .fail_count       (fail_count),
    .pending          (pending),
    .placed_count     (placed_count),
    .infeasible_count (infeasible_count),
    .no_factor_count  (no_factor_count),
    .cleared_count    (cleared_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic offer_request(logic act, logic [15:0] id, logic [12:0] dist_hm,
                               logic [15:0] period, logic [7:0] msgs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {3'b000, msgs, period, dist_hm, id};
    do @(posedge clk); while (!in_tready);
    request_count++;
  endtask

  // Nodes are offered in rising smallest-factor order, which restarts at each call and
  // after each clear; a share of the requests are unsorted noise.
  task automatic random_requests(int count);
    int n;
    int band;
    int stay;
    int roll;
    int dist_lo;
    logic [12:0] dist_hm;
    logic [15:0] period;
    logic [7:0] msgs;
    n = 0;
    band = 0;
    stay = $urandom_range(30, 4);
    while (n < count) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        offer_request(ACT_CLEAR, 16'($urandom), 13'($urandom), 16'($urandom), 8'($urandom));
        band = 0;
        stay = $urandom_range(30, 4);
      end else if (roll < 18) begin
        offer_request(ACT_PLACE, 16'($urandom), 13'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        if (band < 5 && $urandom_range(stay - 1) == 0) band++;
        dist_lo = (band == 0) ? 0 : BAND_TOP[band - 1] + 1;
        dist_hm = 13'($urandom_range(BAND_TOP[band], dist_lo));
        if ($urandom_range(9) == 0) period = 16'($urandom);
        else period = 16'($urandom_range(65535, PERIOD_FLOOR[band]));
        if ($urandom_range(4) == 0) msgs = 8'($urandom_range(20));
        else msgs = 8'($urandom_range(255, 96));
        offer_request(ACT_PLACE, 16'($urandom), dist_hm, period, msgs);
      end
      n++;
    end
  endtask

  initial begin : receiver
    logic hold_used;
    hold_used = 1'b0;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_used) begin
        // A long hold-off while requests keep coming fills the block and stalls its input.
        hold_used = 1'b1;
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("spreading_factor_bin_allocator_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = ACT_PLACE;
    in_tdata = '0;
    hold_armed = 1'b0;
    request_count = 0;
    send_idle_pct = 30;
    recv_idle_pct = 30;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_request(ACT_CLEAR, 16'hffff, 13'h1fff, 16'hffff, 8'hff);
    offer_request(ACT_PLACE, 16'h0000, 13'd0, 16'd65535, 8'd0);
    offer_request(ACT_PLACE, 16'hffff, 13'd124, 16'd101, 8'd255);
    offer_request(ACT_PLACE, 16'h0001, 13'd125, 16'd100, 8'd10);
    offer_request(ACT_PLACE, 16'h0002, 13'd0, 16'd0, 8'd10);
    offer_request(ACT_PLACE, 16'h0003, 13'd249, 16'd201, 8'd1);
    offer_request(ACT_PLACE, 16'h0004, 13'd250, 16'd200, 8'd2);
    offer_request(ACT_PLACE, 16'h0005, 13'd499, 16'd401, 8'd3);
    offer_request(ACT_PLACE, 16'h0006, 13'd500, 16'd801, 8'd255);
    offer_request(ACT_PLACE, 16'h0007, 13'd600, 16'd65535, 8'd255);
    offer_request(ACT_PLACE, 16'h0008, 13'd999, 16'd900, 8'd3);
    offer_request(ACT_PLACE, 16'h0009, 13'd999, 16'd800, 8'd4);
    offer_request(ACT_PLACE, 16'h000a, 13'd1999, 16'd1601, 8'd255);
    offer_request(ACT_PLACE, 16'h000b, 13'd2000, 16'd3201, 8'd255);
    offer_request(ACT_PLACE, 16'h000c, 13'd3999, 16'd65535, 8'd7);
    offer_request(ACT_PLACE, 16'h000d, 13'd4000, 16'd65535, 8'd9);
    offer_request(ACT_PLACE, 16'h000e, 13'h1fff, 16'd65535, 8'd255);
    offer_request(ACT_CLEAR, 16'h1234, 13'h0aaa, 16'h5555, 8'h5a);
    offer_request(ACT_PLACE, 16'haaaa, 13'd3000, 16'd65535, 8'd0);
    offer_request(ACT_PLACE, 16'h5555, 13'd0, 16'd65535, 8'd255);
    offer_request(ACT_PLACE, 16'h0f0f, 13'd1500, 16'd1600, 8'd128);
    offer_request(ACT_PLACE, 16'hf0f0, 13'd4095, 16'd3200, 8'd64);

    send_idle_pct = 21;
    recv_idle_pct = 78;
    random_requests(250);
    send_idle_pct = 78;
    recv_idle_pct = 21;
    random_requests(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed = 1'b1;
    random_requests(250);
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests, directed and in sorted random gateway fills with stalls:",
             request_count);
    $display("%0d placed, %0d infeasible, %0d without a valid factor, %0d bin clears.",
             placed_count, infeasible_count, no_factor_count, cleared_count);
    if (fail_count == 0) begin
      $display("spreading_factor_bin_allocator_unit verification clean");
    end else begin
      $display("spreading_factor_bin_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
